// ===== design/tlpjq_pkg.sv =====
// Shared constants, codes, types and helpers for the three-level priority job queue.
`timescale 1ns / 1ps

package tlpjq_pkg;

  // Queue geometry and payload widths.
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int TIME_WIDTH  = 16;
  localparam int LEVELS      = 3;

  // Derived widths.
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DATA_W      = ID_WIDTH + TIME_WIDTH;
  localparam int SUM_W       = $clog2(STORE_DEPTH + 1);
  localparam int LVL_W       = 2;
  localparam int FIELD_W     = 16;
  localparam int TOTAL_W     = 6;

  // Operation codes.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Job classes; the top three are also the priority levels.
  typedef enum logic [LVL_W-1:0] {
    CLS_HIGH    = 2'd0,
    CLS_MID     = 2'd1,
    CLS_LOW     = 2'd2,
    CLS_UNKNOWN = 2'd3
  } class_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // Pointer update request to the pointer file.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LVL_W-1:0] level;
  } qcmd_t;

  // Pointer file state seen by the controller.
  typedef struct packed {
    logic [LEVELS-1:0][PTR_W-1:0] head;
    logic [LEVELS-1:0][PTR_W-1:0] tail;
    logic [LEVELS-1:0]            full;
    logic [LVL_W-1:0]             top;
    logic                         found;
    logic [SUM_W-1:0]             total;
  } qinfo_t;

  // Store address of one slot of one level.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

// ===== design/three_level_priority_job_queue.sv =====
// Top level of the three-level strict-priority job queue.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid, in_ready   | op, job_class, job_id, service_time
//  out     | out_valid, out_ready | job_valid, out_class, out_job_id,
//          |                      | out_service_time, waiting_time, total_jobs, status
//
// Each input word passes three steps: accept (an add writes the job store), read of the
// head slot of the highest non-empty queue, and commit into the output register.
// The registered read port of the job store sets these steps.
// Reset clears pointers, counts and the waiting time; the job store is not cleared.
// A new word is accepted while a finished result waits; the commit step stalls
// until the output register is free.
`timescale 1ns / 1ps

module three_level_priority_job_queue
  import tlpjq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [LVL_W-1:0]     job_class,
  input  logic [FIELD_W-1:0]   job_id,
  input  logic [FIELD_W-1:0]   service_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 job_valid,
  output logic [LVL_W-1:0]     out_class,
  output logic [FIELD_W-1:0]   out_job_id,
  output logic [FIELD_W-1:0]   out_service_time,
  output logic [FIELD_W-1:0]   waiting_time,
  output logic [TOTAL_W-1:0]   total_jobs,
  output logic [1:0]           status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DATA = 3'b100
  } state_t;

  state_t                state, state_next;
  logic                  op_q;
  status_t               status_q;
  logic [LVL_W-1:0]      top_q;
  logic                  found_q;
  logic [TIME_WIDTH-1:0] waiting, waiting_next;

  qcmd_t                 cmd;
  qinfo_t                info;

  logic                  accept;
  logic                  commit;
  logic                  cls_known;
  logic                  cls_full;
  logic [PTR_W-1:0]      sel_tail;
  logic [PTR_W-1:0]      sel_head;
  logic                  add_ok;
  logic                  pop;
  status_t               acc_status;
  logic [DATA_W-1:0]     rd_data;
  logic [ID_WIDTH-1:0]   rd_id;
  logic [TIME_WIDTH-1:0] rd_time;
  logic [SUM_W-1:0]      total_after;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_DATA) && (!out_valid || out_ready);

  // Tail and full flag of the class being added, head of the top level.
  always_comb begin
    cls_known = 1'b0;
    cls_full  = 1'b0;
    sel_tail  = '0;
    sel_head  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (job_class == LVL_W'(i)) begin
        cls_known = 1'b1;
        cls_full  = info.full[i];
        sel_tail  = info.tail[i];
      end
      if (info.top == LVL_W'(i)) begin
        sel_head = info.head[i];
      end
    end
  end

  // Status known at accept time for add words.
  always_comb begin
    priority if (op == OP_REMOVE) begin
      acc_status = ST_OK;
    end else if (!cls_known) begin
      acc_status = ST_UNKNOWN;
    end else if (cls_full) begin
      acc_status = ST_FULL;
    end else begin
      acc_status = ST_OK;
    end
  end

  assign add_ok = accept && (op == OP_ADD) && cls_known && !cls_full;
  assign pop    = commit && (op_q == OP_REMOVE) && found_q;

  // Pointer file commands: push at accept, pop at commit.
  always_comb begin
    cmd.push  = add_ok;
    cmd.pop   = pop;
    cmd.level = add_ok ? job_class : top_q;
  end

  tlpjq_ptrs u_ptrs (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .info (info)
  );

  // Job store: written at accept, head slot read in the read step.
  tlpjq_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_W)
  ) u_store (
    .clk   (clk),
    .we    (add_ok),
    .waddr (slot_addr(job_class, sel_tail)),
    .wdata ({ID_WIDTH'(job_id), TIME_WIDTH'(service_time)}),
    .re    (state == S_READ),
    .raddr (slot_addr(info.top, sel_head)),
    .rdata (rd_data)
  );

  assign rd_id   = rd_data[DATA_W-1:TIME_WIDTH];
  assign rd_time = rd_data[TIME_WIDTH-1:0];

  // Waiting time follows the top head after every add that finds a job.
  assign waiting_next = (commit && (op_q == OP_ADD) && found_q) ? rd_time : waiting;
  assign total_after  = pop ? info.total - 1'b1 : info.total;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      waiting <= '0;
    end else begin
      state   <= state_next;
      waiting <= waiting_next;
    end
  end

  // Word context held through the read step.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      status_q <= acc_status;
    end
    if (state == S_READ) begin
      top_q   <= info.top;
      found_q <= info.found;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      job_valid        <= pop;
      out_class        <= pop ? top_q : '0;
      out_job_id       <= pop ? FIELD_W'(rd_id) : '0;
      out_service_time <= pop ? FIELD_W'(rd_time) : '0;
      waiting_time     <= FIELD_W'(waiting_next);
      total_jobs       <= TOTAL_W'(total_after);
      status           <= ((op_q == OP_REMOVE) && !found_q) ? ST_EMPTY : status_q;
    end
  end

  // A removed job always comes with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && job_valid |-> status == ST_OK)
    else $error("job given out with a failure status");

  // An accepted word always goes on to the store read.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted word did not start a read");

  // The read step always hands over to the commit step.
  assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_DATA)
    else $error("read step not followed by commit step");

  // The job count never goes beyond the store size.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_jobs <= TOTAL_W'(STORE_DEPTH))
    else $error("total job count beyond store size");

endmodule

// ===== design/tlpjq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module tlpjq_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data appears in the cycle after the enable and then holds.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tlpjq_ptrs.sv =====
// Head and tail pointers, fill counts and priority selection of the three queues.
`timescale 1ns / 1ps

module tlpjq_ptrs
  import tlpjq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qcmd_t  cmd,
  output qinfo_t info
);

  logic [LEVELS-1:0][PTR_W-1:0] head;
  logic [LEVELS-1:0][PTR_W-1:0] tail;
  logic [LEVELS-1:0][CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointer and count updates; a push and a pop never come in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (cmd.push && cmd.level == LVL_W'(i)) begin
          tail[i]  <= ptr_inc(tail[i]);
          count[i] <= count[i] + 1'b1;
        end else if (cmd.pop && cmd.level == LVL_W'(i)) begin
          head[i]  <= ptr_inc(head[i]);
          count[i] <= count[i] - 1'b1;
        end
      end
    end
  end

  // Full flags, highest non-empty level and total job count.
  always_comb begin
    info.head  = head;
    info.tail  = tail;
    info.found = 1'b0;
    info.top   = CLS_UNKNOWN;
    info.total = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      info.full[i] = (count[i] == CNT_W'(QUEUE_DEPTH));
      if (count[i] != '0) begin
        info.found = 1'b1;
        info.top   = LVL_W'(i);
      end
      info.total = info.total + SUM_W'(count[i]);
    end
  end

endmodule
